// ===== rtl/xos_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xos_pkg
// shared types and constants of the xoshiro128** generator with seeding
// ----------------------------------------------------------------------------
package xos_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned NWORDS  = 4;
    localparam int unsigned IDX_W   = 2;

    // splitmix32 constants
    localparam logic [WORD_W-1:0] SM_GOLDEN = 32'h9E37_79B9;
    localparam logic [WORD_W-1:0] SM_MUL_A  = 32'h21F0_AAAD;
    localparam logic [WORD_W-1:0] SM_MUL_B  = 32'h735A_2D97;

    // item codes
    localparam logic ACT_SEED = 1'b0;
    localparam logic ACT_DRAW = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX_A,
        ST_MIX_B,
        ST_STORE,
        ST_OUT
    } xos_state_t;

    typedef struct packed {
        logic             acc_load;
        logic             mix_a;
        logic             mix_b;
        logic             store;
        logic [IDX_W-1:0] store_idx;
        logic             draw;
        logic             out_load;
    } xos_cmd_t;

    typedef struct packed {
        logic out_free;
    } xos_status_t;

endpackage : xos_pkg
`default_nettype wire

// ===== rtl/xoshiro128ss_prng_with_seeding.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xoshiro128ss_prng_with_seeding
// xoshiro128** generator with splitmix32 seeding
// ----------------------------------------------------------------------------
// A seed word (action 0) loads the four 32-bit state words with four
// successive splitmix32 outputs of seed_value and gives no result; it occupies
// the block (the accept, then the states MIX_A, MIX_B and STORE for each state
// word through the shared mixing unit, whose two 32x32 multiplies are each
// registered). A draw word (action 1) gives one result word: random_word =
// rotl(s1*5,7)*9 of the state before the advance, its low byte, and
// bounded_value = (random_word*bound)>>32. In a draw the scrambled word is
// registered while the state advances, then, once the output register is free,
// the 32x8 bound multiply fills it; the block takes no new word until then.
// The output register lets the next word be accepted while a result still
// waits. After reset the state is all zero, a fixed point of the advance rule,
// so draws before any seed give zeros.
// ----------------------------------------------------------------------------
module xoshiro128ss_prng_with_seeding (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // input channel
    input  wire logic                       in_valid,
    output      logic                       in_stall,
    input  wire logic                       action,
    input  wire logic [xos_pkg::WORD_W-1:0] seed_value,
    input  wire logic [xos_pkg::BYTE_W-1:0] bound,
    // output channel
    output      logic                       out_valid,
    input  wire logic                       out_stall,
    output      logic [xos_pkg::WORD_W-1:0] random_word,
    output      logic [xos_pkg::BYTE_W-1:0] random_low_byte,
    output      logic [xos_pkg::BYTE_W-1:0] bounded_value
);
    import xos_pkg::*;

    // commands from the sequencer, output-register status back to it
    xos_cmd_t    cmd;
    xos_status_t status;

    xos_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .status   (status),
        .cmd      (cmd)
    );

    // state words, mixing unit, scrambler and output register
    xos_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .seed_value      (seed_value),
        .bound           (bound),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .random_word     (random_word),
        .random_low_byte (random_low_byte),
        .bounded_value   (bounded_value)
    );

endmodule : xoshiro128ss_prng_with_seeding
`default_nettype wire

// ===== rtl/xos_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xos_datapath
// generator state, splitmix32 mixing unit, scrambler and output register
// ----------------------------------------------------------------------------
module xos_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire xos_pkg::xos_cmd_t            cmd,
    output      xos_pkg::xos_status_t         status,
    input  wire logic [xos_pkg::WORD_W-1:0]   seed_value,
    input  wire logic [xos_pkg::BYTE_W-1:0]   bound,
    output      logic                         out_valid,
    input  wire logic                         out_stall,
    output      logic [xos_pkg::WORD_W-1:0]   random_word,
    output      logic [xos_pkg::BYTE_W-1:0]   random_low_byte,
    output      logic [xos_pkg::BYTE_W-1:0]   bounded_value
);
    import xos_pkg::*;

    logic [WORD_W-1:0] gen_state_reg [NWORDS];
    logic [WORD_W-1:0] gen_state_next [NWORDS];
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] mix_reg, mix_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [BYTE_W-1:0] bound_reg, bound_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_word_reg, out_word_next;
    logic [BYTE_W-1:0] out_bnd_reg, out_bnd_next;

    logic [WORD_W-1:0] acc_inc, mix_in_a, mix_in_b, mix_out;
    logic [WORD_W-1:0] s1x5, s1rot, scrambled;
    logic [WORD_W-1:0] t2, t3;
    logic [WORD_W+BYTE_W-1:0] scaled;

    // splitmix32 steps
    assign acc_inc  = acc_reg + SM_GOLDEN;
    assign mix_in_a = acc_inc ^ (acc_inc >> 16);
    assign mix_in_b = mix_reg ^ (mix_reg >> 15);
    assign mix_out  = mix_reg ^ (mix_reg >> 15);

    // scrambler: rotl(s1*5,7)*9 with shift-add products
    assign s1x5      = gen_state_reg[1] + (gen_state_reg[1] << 2);
    assign s1rot     = {s1x5[WORD_W-8:0], s1x5[WORD_W-1:WORD_W-7]};
    assign scrambled = s1rot + (s1rot << 3);

    // state advance
    assign t2 = gen_state_reg[2] ^ gen_state_reg[0];
    assign t3 = gen_state_reg[3] ^ gen_state_reg[1];

    assign scaled = {{BYTE_W{1'b0}}, word_reg} * {{WORD_W{1'b0}}, bound_reg};

    always_comb
    begin
        gen_state_next = gen_state_reg;
        acc_next       = acc_reg;
        mix_next       = mix_reg;
        word_next      = word_reg;
        bound_next     = bound_reg;
        out_word_next  = out_word_reg;
        out_bnd_next   = out_bnd_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.acc_load)
        begin
            acc_next = seed_value;
        end
        if (cmd.mix_a)
        begin
            acc_next = acc_inc;
            mix_next = mix_in_a * SM_MUL_A;
        end
        if (cmd.mix_b)
        begin
            mix_next = mix_in_b * SM_MUL_B;
        end
        if (cmd.store)
        begin
            gen_state_next[cmd.store_idx] = mix_out;
        end
        if (cmd.draw)
        begin
            word_next         = scrambled;
            bound_next        = bound;
            gen_state_next[0] = gen_state_reg[0] ^ t3;
            gen_state_next[1] = gen_state_reg[1] ^ t2;
            gen_state_next[2] = t2 ^ (gen_state_reg[1] << 9);
            gen_state_next[3] = {t3[WORD_W-12:0], t3[WORD_W-1:WORD_W-11]};
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_word_next  = word_reg;
            out_bnd_next   = scaled[WORD_W+BYTE_W-1:WORD_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NWORDS; i++)
            begin
                gen_state_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            gen_state_reg <= gen_state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        mix_reg      <= mix_next;
        word_reg     <= word_next;
        bound_reg    <= bound_next;
        out_word_reg <= out_word_next;
        out_bnd_reg  <= out_bnd_next;
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign random_word     = out_word_reg;
    assign random_low_byte = out_word_reg[BYTE_W-1:0];
    assign bounded_value   = out_bnd_reg;

endmodule : xos_datapath
`default_nettype wire

// ===== rtl/xos_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xos_ctrl
// sequencer for seed mixing and draws
// ----------------------------------------------------------------------------
module xos_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output      logic                 in_stall,
    input  wire logic                 action,
    input  wire xos_pkg::xos_status_t status,
    output      xos_pkg::xos_cmd_t    cmd
);
    import xos_pkg::*;

    xos_state_t       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cmd           = '0;
        cmd.store_idx = idx_reg;
        in_stall      = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (action == ACT_SEED)
                    begin
                        cmd.acc_load = 1'b1;
                        idx_next     = '0;
                        state_next   = ST_MIX_A;
                    end
                    else
                    begin
                        cmd.draw   = 1'b1;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_MIX_A:
            begin
                cmd.mix_a  = 1'b1;
                state_next = ST_MIX_B;
            end
            ST_MIX_B:
            begin
                cmd.mix_b  = 1'b1;
                state_next = ST_STORE;
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(NWORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_MIX_A;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule : xos_ctrl
`default_nettype wire

// ===== rtl/xos_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xos_checker
// port-level checks of the generator, bound to the top level
// ----------------------------------------------------------------------------
module xos_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_stall,
    input wire logic                       action,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire logic [xos_pkg::WORD_W-1:0] random_word,
    input wire logic [xos_pkg::BYTE_W-1:0] random_low_byte
);
    import xos_pkg::*;

    // one word at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken on consecutive cycles");

    // a seed word never produces a result
    a_seed_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && action == ACT_SEED) |=> !$rose(out_valid))
        else $error("result after seed word");

    // low byte tracks the word
    a_low_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (random_low_byte == random_word[BYTE_W-1:0]))
        else $error("low byte mismatch");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result dropped");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(random_word))
        else $error("stalled result changed");

endmodule : xos_checker

bind xoshiro128ss_prng_with_seeding xos_checker u_xos_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .random_word     (random_word),
    .random_low_byte (random_low_byte)
);
`default_nettype wire

// ===== verif/tb_xoshiro128ss_prng_with_seeding.sv =====
// ----------------------------------------------------------------------------
// tb_xoshiro128ss_prng_with_seeding
// self-checking bench for the xoshiro128** generator with splitmix32 seeding
// ----------------------------------------------------------------------------
// A directed table covers draws from the all-zero reset state, the field
// extremes, back-to-back seeds and a seed that wraps the splitmix counter to
// zero. A long random run of seed and draw words follows. An in-bench model
// of the generator predicts every draw result. The sender works in bursts
// and the receiver stalls in changing patterns. Three times the receiver holds
// off long enough to back the block up, and once the sender drains the block.
// ----------------------------------------------------------------------------
module tb_xoshiro128ss_prng_with_seeding;
    import xos_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int RAND_WORDS     = 1500;
    localparam int HOLD_CYCLES    = 80;     // long receiver hold-off
    localparam int PRESSURE_BURST = 40;     // back-to-back words during a hold-off
    localparam int DRAIN_AT       = 750;    // random word count where the sender drains
    localparam int TAIL_CYCLES    = 30;     // idle tail, longer than a seed occupies the block
    localparam int TIMEOUT_CYCLES = 400000;

    // splitmix32 and scrambler constants, kept apart from the package
    localparam logic [31:0] GOLDEN_STEP = 32'h9E37_79B9;
    localparam logic [31:0] MIX_MUL1    = 32'h21F0_AAAD;
    localparam logic [31:0] MIX_MUL2    = 32'h735A_2D97;

    typedef struct packed {
        logic [31:0] word;
        logic [7:0]  low;
        logic [7:0]  scaled;
    } draw_result_t;

    typedef struct packed {
        logic         act;
        logic [31:0]  sd;
        logic [7:0]   bnd;
        logic         typed;    // expected result given in the row
        draw_result_t res;
    } stim_row_t;

    localparam draw_result_t ZERO_RES = '{32'h0, 8'h0, 8'h0};
    localparam draw_result_t NO_RES   = '{32'h0, 8'h0, 8'h0};

    localparam int N_DIRECTED = 20;

    // directed table: rows with typed set carry their result, the rest use the model
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // draws before any seed: the zero state is a fixed point
        '{ACT_DRAW, 32'h0000_0000, 8'h00, 1'b1, ZERO_RES},
        '{ACT_DRAW, 32'hFFFF_FFFF, 8'hFF, 1'b1, ZERO_RES},
        '{ACT_DRAW, 32'h5A5A_5A5A, 8'h01, 1'b1, ZERO_RES},
        // zero seed, then bound extremes
        '{ACT_SEED, 32'h0000_0000, 8'h00, 1'b0, NO_RES},
        '{ACT_DRAW, 32'h0000_0000, 8'h00, 1'b0, NO_RES},
        '{ACT_DRAW, 32'h0000_0000, 8'hFF, 1'b0, NO_RES},
        '{ACT_DRAW, 32'h0000_0000, 8'h01, 1'b0, NO_RES},
        '{ACT_DRAW, 32'hFFFF_FFFF, 8'h80, 1'b0, NO_RES},
        // all-ones seed with a bound that is ignored
        '{ACT_SEED, 32'hFFFF_FFFF, 8'hFF, 1'b0, NO_RES},
        '{ACT_DRAW, 32'h0000_0000, 8'hFF, 1'b0, NO_RES},
        '{ACT_DRAW, 32'h0000_0000, 8'h00, 1'b0, NO_RES},
        // back-to-back seeds, only the second one counts
        '{ACT_SEED, 32'h8000_0000, 8'h00, 1'b0, NO_RES},
        '{ACT_SEED, 32'h0000_0001, 8'h00, 1'b0, NO_RES},
        '{ACT_DRAW, 32'h0000_0000, 8'hFF, 1'b0, NO_RES},
        '{ACT_DRAW, 32'h0000_0000, 8'hAA, 1'b0, NO_RES},
        '{ACT_DRAW, 32'h0000_0000, 8'h55, 1'b0, NO_RES},
        // seed whose first splitmix counter step wraps to zero
        '{ACT_SEED, 32'h61C8_8647, 8'h00, 1'b0, NO_RES},
        '{ACT_DRAW, 32'h0000_0000, 8'hFF, 1'b0, NO_RES},
        '{ACT_DRAW, 32'h0000_0000, 8'h7F, 1'b0, NO_RES},
        '{ACT_DRAW, 32'h0000_0000, 8'hFE, 1'b0, NO_RES}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [31:0] seed_value;
    logic [7:0]  bound;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] random_word;
    logic [7:0]  random_low_byte;
    logic [7:0]  bounded_value;

    // model of the generator state
    logic [31:0] gen_words [4];

    draw_result_t pending_draws [$];
    draw_result_t want;

    int err_count  = 0;
    int n_seeds    = 0;
    int n_draws    = 0;
    int n_checked  = 0;
    int n_holds    = 0;

    // receiver stall control
    bit long_hold_req = 1'b0;
    int hold_left     = 0;
    int phase_left    = 0;
    int stall_mode    = 0;

    always #(CLK_PERIOD/2) clk = ~clk;

    xoshiro128ss_prng_with_seeding u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .seed_value      (seed_value),
        .bound           (bound),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .random_word     (random_word),
        .random_low_byte (random_low_byte),
        .bounded_value   (bounded_value)
    );

    // ------------------------------------------------------------------------
    // generator model
    // ------------------------------------------------------------------------

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned k);
        return (x << k) | (x >> (32 - k));
    endfunction

    // four successive splitmix32 outputs of the seed fill the state
    function automatic void seed_state(input logic [31:0] sd);
        logic [31:0] acc;
        logic [31:0] z;
        acc = sd;
        for (int i = 0; i < 4; i++)
        begin
            acc = acc + GOLDEN_STEP;
            z = acc;
            z = z ^ (z >> 16);
            z = z * MIX_MUL1;
            z = z ^ (z >> 15);
            z = z * MIX_MUL2;
            z = z ^ (z >> 15);
            gen_words[i] = z;
        end
    endfunction

    // scrambled word of the current state, then the xor/shift/rotate advance
    function automatic draw_result_t next_draw(input logic [7:0] bnd);
        draw_result_t r;
        logic [31:0]  w;
        logic [31:0]  sh;
        logic [39:0]  prod;
        w  = rotl32(gen_words[1] * 32'd5, 7) * 32'd9;
        sh = gen_words[1] << 9;
        gen_words[2] = gen_words[2] ^ gen_words[0];
        gen_words[3] = gen_words[3] ^ gen_words[1];
        gen_words[1] = gen_words[1] ^ gen_words[2];
        gen_words[0] = gen_words[0] ^ gen_words[3];
        gen_words[2] = gen_words[2] ^ sh;
        gen_words[3] = rotl32(gen_words[3], 11);
        prod     = {8'h00, w} * {32'h0, bnd};
        r.word   = w;
        r.low    = w[7:0];
        r.scaled = prod[39:32];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------

    // offer one word from a falling edge until it is taken; the model is
    // updated at the accepting edge, and the task returns on a falling edge
    task automatic offer(input logic act, input logic [31:0] sd, input logic [7:0] bnd,
                         input logic typed, input draw_result_t typed_res);
        logic         took;
        draw_result_t r;
        in_valid   <= 1'b1;
        action     <= act;
        seed_value <= sd;
        bound      <= bnd;
        took = 1'b0;
        while (!took)
        begin
            @(posedge clk);
            took = !in_stall;
            if (took)
            begin
                if (act == ACT_DRAW)
                begin
                    r = next_draw(bnd);
                    pending_draws.push_back(typed ? typed_res : r);
                    n_draws++;
                end
                else
                begin
                    seed_state(sd);
                    n_seeds++;
                end
            end
            @(negedge clk);
        end
    endtask

    // drop valid for a number of cycles; zero leaves valid up
    task automatic idle_for(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // random word: mostly draws, seeds and bounds lean toward the extremes now and then
    task automatic offer_random();
        logic        act;
        logic [31:0] sd;
        logic [7:0]  bnd;
        act = ($urandom_range(0, 9) < 3) ? ACT_SEED : ACT_DRAW;
        case ($urandom_range(0, 9))
            0:       sd = 32'h0000_0000;
            1:       sd = 32'hFFFF_FFFF;
            default: sd = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0:       bnd = 8'h00;
            1:       bnd = 8'hFF;
            2:       bnd = 8'h01;
            default: bnd = 8'($urandom_range(0, 255));
        endcase
        offer(act, sd, bnd, 1'b0, NO_RES);
    endtask

    initial
    begin
        int rand_sent;
        int burst;
        int next_hold;
        bit drained;
        rand_sent  = 0;
        next_hold  = 300;
        drained    = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = ACT_DRAW;
        seed_value = '0;
        bound      = '0;
        gen_words  = '{32'h0, 32'h0, 32'h0, 32'h0};

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table, mostly back to back with an occasional gap
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            offer(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].sd, DIRECTED_ROWS[i].bnd,
                  DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
            if ($urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 4));
        end

        // random part in bursts
        while (rand_sent < RAND_WORDS)
        begin
            if (rand_sent >= next_hold)
            begin
                // receiver holds off while the sender keeps offering, so the
                // output backs up and the input stalls
                long_hold_req = 1'b1;
                n_holds++;
                burst = PRESSURE_BURST;
                next_hold += 500;
            end
            else
                burst = $urandom_range(1, 24);

            for (int k = 0; k < burst && rand_sent < RAND_WORDS; k++)
            begin
                offer_random();
                rand_sent++;
            end

            if (!drained && rand_sent >= DRAIN_AT)
            begin
                // pause until every expected result has come back
                drained = 1'b1;
                in_valid <= 1'b0;
                while (pending_draws.size() != 0)
                    @(negedge clk);
                idle_for(TAIL_CYCLES);
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0, 1:    idle_for(0);
                    2:       idle_for($urandom_range(10, 30));
                    default: idle_for($urandom_range(1, 8));
                endcase
            end
        end

        // let the block empty out, then an idle tail for stray results
        in_valid <= 1'b0;
        while (pending_draws.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("%0d words taken (%0d seeds, %0d draws), %0d results compared",
                 n_seeds + n_draws, n_seeds, n_draws, n_checked);
        $display("%0d long receiver hold-offs, one full drain, %0d mismatches",
                 n_holds, err_count);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: stall pattern in phases of random mode and length, plus the
    // long hold-off that the sender asks for
    // ------------------------------------------------------------------------
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    phase_left = $urandom_range(16, 160);
                end
                phase_left--;
                case (stall_mode)
                    0:       out_stall <= 1'b0;                          // free running
                    1:       out_stall <= ($urandom_range(0, 3) == 0);   // light
                    2:       out_stall <= ($urandom_range(0, 3) != 0);   // heavy
                    default: out_stall <= ~out_stall;                    // alternating
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checker: every taken result against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_draws.size() == 0)
            begin
                $error("unexpected result word: random_word %h", random_word);
                err_count++;
            end
            else
            begin
                want = pending_draws.pop_front();
                n_checked++;
                if (random_word !== want.word)
                begin
                    $error("random_word: expected %h, got %h", want.word, random_word);
                    err_count++;
                end
                if (random_low_byte !== want.low)
                begin
                    $error("random_low_byte: expected %h, got %h", want.low,
                           random_low_byte);
                    err_count++;
                end
                if (bounded_value !== want.scaled)
                begin
                    $error("bounded_value: expected %h, got %h", want.scaled,
                           bounded_value);
                    err_count++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d results outstanding", pending_draws.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
